// File: src/tmvg_pkg.sv
`default_nettype none
package tmvg_pkg;

    localparam int MAX_DIVISIONS = 256;

    // pipelined divider: four quotient bits per stage
    localparam int DIV_STAGES = 6;
    localparam int DIV_STEP   = 4;
    localparam int NUM_W      = DIV_STAGES * DIV_STEP;

    // sine unit: fold, square, four horner steps, final product, round
    localparam int SIN_STAGES = 8;
    localparam int HORNER_N   = 4;

    localparam int META_LEN = DIV_STAGES + SIN_STAGES + 2;
    localparam int TEX_LEN  = SIN_STAGES + 2;
    localparam int PIPE_LEN = META_LEN + 1;

    localparam int TDATA_W = 184;

    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598670;
    localparam logic [31:0] K5 = 32'd85569305;
    localparam logic [31:0] K7 = 32'd5026994;
    localparam logic [31:0] K9 = 32'd172272;

    localparam logic [31:0] HORNER_K [HORNER_N] = '{K7, K5, K3, K1};

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_REJECT   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_RING_RADIUS = 2'd0,
        CFG_TUBE_RADIUS = 2'd1,
        CFG_ROWS_COUNT  = 2'd2,
        CFG_COLS_COUNT  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               reject;
        logic               interior;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [15:0]        p00;
        logic [15:0]        p01;
        logic [15:0]        p10;
        logic [15:0]        p11;
    } item_t;

    // divide by 2^sh, rounding half away from zero
    function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                       input int sh);
        logic signed [47:0] half;
        logic signed [47:0] mag;
        half = 48'sd1 <<< (sh - 1);
        if (v >= 0)
        begin
            round_shift = (v + half) >>> sh;
        end
        else
        begin
            mag = ((-v) + half) >>> sh;
            round_shift = -mag;
        end
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
        if (v > 48'sd131071)
        begin
            sat18 = 18'sd131071;
        end
        else if (v < -48'sd131072)
        begin
            sat18 = -18'sd131072;
        end
        else
        begin
            sat18 = v[17:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: src/tmvg_div.sv
`default_nettype none
module tmvg_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [tmvg_pkg::NUM_W-1:0]  num,
    input  wire logic [7:0]                  den,
    output logic      [16:0]                 quo
);

    logic [8:0]                 rem_reg [tmvg_pkg::DIV_STAGES];
    logic [tmvg_pkg::NUM_W-1:0] w_reg   [tmvg_pkg::DIV_STAGES];
    logic [8:0]                 rem_src [tmvg_pkg::DIV_STAGES];
    logic [tmvg_pkg::NUM_W-1:0] w_src   [tmvg_pkg::DIV_STAGES];
    logic [8:0]                 rem_next[tmvg_pkg::DIV_STAGES];
    logic [tmvg_pkg::NUM_W-1:0] w_next  [tmvg_pkg::DIV_STAGES];

    always_comb
    begin
        rem_src[0] = 9'd0;
        w_src[0]   = num;
        for (int k = 1; k < tmvg_pkg::DIV_STAGES; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            w_src[k]   = w_reg[k-1];
        end
    end

    // restoring division, dividend bits shift out the top while quotient bits enter below
    always_comb
    begin
        logic [8:0]                   r;
        logic [tmvg_pkg::DIV_STEP-1:0] q;
        for (int k = 0; k < tmvg_pkg::DIV_STAGES; k++)
        begin
            r = rem_src[k];
            q = '0;
            for (int j = 0; j < tmvg_pkg::DIV_STEP; j++)
            begin
                r = {r[7:0], w_src[k][tmvg_pkg::NUM_W-1-j]};
                if (r >= {1'b0, den})
                begin
                    r = r - {1'b0, den};
                    q[tmvg_pkg::DIV_STEP-1-j] = 1'b1;
                end
            end
            rem_next[k] = r;
            w_next[k]   = {w_src[k][tmvg_pkg::NUM_W-tmvg_pkg::DIV_STEP-1:0], q};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < tmvg_pkg::DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                w_reg[k]   <= w_next[k];
            end
        end
    end

    assign quo = w_reg[tmvg_pkg::DIV_STAGES-1][16:0];

endmodule
`default_nettype wire

// File: src/tmvg_sin.sv
`default_nettype none
module tmvg_sin (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [15:0]        angle,
    output logic signed [15:0]      value
);

    logic        neg_reg [7];
    logic [30:0] x_reg   [6];
    logic [30:0] x2_reg  [tmvg_pkg::HORNER_N];
    logic [31:0] s_reg   [tmvg_pkg::HORNER_N];
    logic [31:0] y_reg;
    logic signed [15:0] value_reg;

    logic [14:0] fold;
    logic [30:0] x_next;
    logic [61:0] sq_prod;
    logic [31:0] s_src   [tmvg_pkg::HORNER_N];
    logic [62:0] h_prod  [tmvg_pkg::HORNER_N];
    logic [31:0] s_next  [tmvg_pkg::HORNER_N];
    logic [62:0] y_prod;
    logic [32:0] y_sum;
    logic [16:0] y_round;
    logic [15:0] y_clamp;
    logic signed [15:0] value_next;

    // fold the quarter wave, odd quarters run backward
    always_comb
    begin
        if (angle[14])
        begin
            fold = 15'd16384 - {1'b0, angle[13:0]};
        end
        else
        begin
            fold = {1'b0, angle[13:0]};
        end
        x_next  = {fold, 16'h0000};
        sq_prod = x_reg[0] * x_reg[0];
    end

    always_comb
    begin
        s_src[0] = tmvg_pkg::K9;
        for (int i = 1; i < tmvg_pkg::HORNER_N; i++)
        begin
            s_src[i] = s_reg[i-1];
        end
        for (int i = 0; i < tmvg_pkg::HORNER_N; i++)
        begin
            h_prod[i] = s_src[i] * x2_reg[i];
            s_next[i] = tmvg_pkg::HORNER_K[i] - h_prod[i][61:30];
        end
    end

    always_comb
    begin
        y_prod  = s_reg[tmvg_pkg::HORNER_N-1] * x_reg[5];
        y_sum   = {1'b0, y_reg} + 33'd32768;
        y_round = y_sum[32:16];
        if (y_round > 17'd16384)
        begin
            y_clamp = 16'd16384;
        end
        else
        begin
            y_clamp = y_round[15:0];
        end
        if (neg_reg[6])
        begin
            value_next = -$signed(y_clamp);
        end
        else
        begin
            value_next = $signed(y_clamp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= angle[15];
            x_reg[0]   <= x_next;
            for (int i = 1; i < 7; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
            for (int i = 1; i < 6; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            x2_reg[0] <= sq_prod[60:30];
            for (int i = 1; i < tmvg_pkg::HORNER_N; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end
            for (int i = 0; i < tmvg_pkg::HORNER_N; i++)
            begin
                s_reg[i] <= s_next[i];
            end
            y_reg     <= y_prod[61:30];
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// File: src/tmvg_emit.sv
`default_nettype none
module tmvg_emit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tmvg_pkg::item_t                 item,
    input  wire logic                            item_valid,
    output logic                                 done,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tmvg_pkg::TDATA_W-1:0]         m_tdata,  // pos_x, pos_y, pos_z, norm_x,
                                                           // norm_y, norm_z, tex_u, tex_v,
                                                           // corners
    output logic [1:0]                           m_tuser,  // kind
    output logic                                 m_tlast
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       fire;
    tmvg_pkg::kind_t kind;
    logic [47:0] corners;
    logic        vert;

    always_comb
    begin
        kind    = tmvg_pkg::KIND_VERTEX;
        m_tlast = 1'b0;
        corners = '0;
        vert    = 1'b0;
        case (phase_reg)
            2'd0:
            begin
                if (item.reject)
                begin
                    kind    = tmvg_pkg::KIND_REJECT;
                    m_tlast = 1'b1;
                end
                else
                begin
                    vert    = 1'b1;
                    m_tlast = !item.interior;
                end
            end
            2'd1:
            begin
                kind    = tmvg_pkg::KIND_TRIANGLE;
                corners = {item.p01, item.p10, item.p00};
            end
            default:
            begin
                kind    = tmvg_pkg::KIND_TRIANGLE;
                m_tlast = 1'b1;
                corners = {item.p11, item.p10, item.p01};
            end
        endcase
    end

    always_comb
    begin
        m_tvalid = item_valid;
        m_tuser  = kind;
        if (vert)
        begin
            m_tdata = {corners, item.tex_v, item.tex_u, item.norm_z, item.norm_y, item.norm_x,
                       item.pos_z, item.pos_y, item.pos_x};
        end
        else
        begin
            m_tdata = {corners, 136'd0};
        end
        fire = m_tvalid && m_tready;
        done = fire && m_tlast;
        if (done)
        begin
            phase_next = 2'd0;
        end
        else if (fire)
        begin
            phase_next = phase_reg + 2'd1;
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// File: src/torus_mesh_vertex_generator.sv
`default_nettype none
// torus mesh vertex generator
// s_tdata carries one grid point request (grid_row in bits 7:0, grid_col in 15:8).
// each point gives a vertex result on m_*, then two triangle results when the point
// is not on the last row or column; an out-of-range point gives one reject result.
// m_tuser is the result kind, m_tlast marks the final result of a request.
// the cfg channel writes ring_radius, tube_radius, rows_count, cols_count by index;
// it is always ready and must only be used while no request is in flight.
// a request passes through 17 register stages (6 divider, 8 sine, 3 product and rounding)
// before its first result is valid on m_*.
// edge points are taken at one request per cycle while m_tready is high; interior points
// give three results each, and the pipeline holds until the last of them is taken.
// the whole pipeline holds while the last stage holds a request whose final result is not
// taken, and s_tready is low then too; nothing is lost or repeated.
// reset returns the registers to R=1.0, r=0.25, 20 by 20 divisions and empties
// the pipeline.
module torus_mesh_vertex_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,  // grid_row, grid_col
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tmvg_pkg::TDATA_W-1:0]         m_tdata,  // pos_x, pos_y, pos_z, norm_x,
                                                           // norm_y, norm_z, tex_u, tex_v,
                                                           // corners
    output logic [1:0]                           m_tuser,  // kind
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [15:0]                     cfg_data
);

    logic [15:0] ring_radius_reg;
    logic [15:0] tube_radius_reg;
    logic [8:0]  rows_count_reg;
    logic [8:0]  cols_count_reg;

    logic en;
    logic done;

    logic        vld_reg  [tmvg_pkg::PIPE_LEN];
    logic [15:0] meta_reg [tmvg_pkg::META_LEN];
    logic [16:0] tu_reg   [tmvg_pkg::TEX_LEN];
    logic [16:0] tv_reg   [tmvg_pkg::TEX_LEN];

    logic [8:0]  rows_m1;
    logic [8:0]  cols_m1;
    logic [tmvg_pkg::NUM_W-1:0] num_u;
    logic [tmvg_pkg::NUM_W-1:0] num_v;
    logic [16:0] tu_div;
    logic [16:0] tv_div;
    logic [15:0] ang_cu;
    logic [15:0] ang_cv;
    logic signed [15:0] su;
    logic signed [15:0] cu;
    logic signed [15:0] sv;
    logic signed [15:0] cv;

    // product stages
    logic signed [31:0] rad_reg;
    logic signed [15:0] cu1_reg;
    logic signed [15:0] su1_reg;
    logic signed [32:0] pyp_reg;
    logic signed [31:0] nxp_reg;
    logic signed [31:0] nzp_reg;
    logic signed [15:0] ny1_reg;
    logic signed [47:0] pxp_reg;
    logic signed [47:0] pzp_reg;
    logic signed [32:0] pyp2_reg;
    logic signed [31:0] nxp2_reg;
    logic signed [31:0] nzp2_reg;
    logic signed [15:0] ny2_reg;
    tmvg_pkg::item_t    item_reg;

    logic signed [32:0] rad_full;
    logic signed [32:0] pyp_next;
    logic signed [31:0] nxp_next;
    logic signed [31:0] nzp_next;
    logic signed [47:0] pxp_next;
    logic signed [47:0] pzp_next;
    tmvg_pkg::item_t    item_next;
    logic [7:0]         row_l;
    logic [7:0]         col_l;
    logic [16:0]        idx_prod;
    logic               bad_counts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_radius_reg <= 16'd4096;
            tube_radius_reg <= 16'd1024;
            rows_count_reg  <= 9'd20;
            cols_count_reg  <= 9'd20;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tmvg_pkg::CFG_RING_RADIUS: ring_radius_reg <= cfg_data;
                tmvg_pkg::CFG_TUBE_RADIUS: tube_radius_reg <= cfg_data;
                tmvg_pkg::CFG_ROWS_COUNT:  rows_count_reg  <= cfg_data[8:0];
                tmvg_pkg::CFG_COLS_COUNT:  cols_count_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // global hold: the last stage waits until its final result is taken
    assign en       = !vld_reg[tmvg_pkg::PIPE_LEN-1] || done;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tmvg_pkg::PIPE_LEN; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < tmvg_pkg::PIPE_LEN; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // texture coordinate: round(row * 65536 / (rows - 1)) through the divider
    assign rows_m1 = rows_count_reg - 9'd1;
    assign cols_m1 = cols_count_reg - 9'd1;
    assign num_u   = {s_tdata[7:0], 16'h0000} + {17'd0, rows_m1[7:1]};
    assign num_v   = {s_tdata[15:8], 16'h0000} + {17'd0, cols_m1[7:1]};

    tmvg_div u_div_u (
        .clk (clk),
        .en  (en),
        .num (num_u),
        .den (rows_m1[7:0]),
        .quo (tu_div)
    );

    tmvg_div u_div_v (
        .clk (clk),
        .en  (en),
        .num (num_v),
        .den (cols_m1[7:0]),
        .quo (tv_div)
    );

    assign ang_cu = tu_div[15:0] + 16'd16384;
    assign ang_cv = tv_div[15:0] + 16'd16384;

    tmvg_sin u_sin_su (.clk(clk), .en(en), .angle(tu_div[15:0]), .value(su));
    tmvg_sin u_sin_cu (.clk(clk), .en(en), .angle(ang_cu),       .value(cu));
    tmvg_sin u_sin_sv (.clk(clk), .en(en), .angle(tv_div[15:0]), .value(sv));
    tmvg_sin u_sin_cv (.clk(clk), .en(en), .angle(ang_cv),       .value(cv));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= s_tdata;
            for (int i = 1; i < tmvg_pkg::META_LEN; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
            tu_reg[0] <= tu_div;
            tv_reg[0] <= tv_div;
            for (int i = 1; i < tmvg_pkg::TEX_LEN; i++)
            begin
                tu_reg[i] <= tu_reg[i-1];
                tv_reg[i] <= tv_reg[i-1];
            end
        end
    end

    // products: tube center distance, y position and normal terms, then x and z positions from the distance
    always_comb
    begin
        rad_full = $signed({3'b000, ring_radius_reg, 14'h0000})
                 + $signed({1'b0, tube_radius_reg}) * cv;
        pyp_next = $signed({1'b0, tube_radius_reg}) * sv;
        nxp_next = cv * cu;
        nzp_next = cv * su;
        pxp_next = rad_reg * cu1_reg;
        pzp_next = rad_reg * su1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_full[31:0];
            cu1_reg  <= cu;
            su1_reg  <= su;
            pyp_reg  <= pyp_next;
            nxp_reg  <= nxp_next;
            nzp_reg  <= nzp_next;
            ny1_reg  <= sv;
            pxp_reg  <= pxp_next;
            pzp_reg  <= pzp_next;
            pyp2_reg <= pyp_reg;
            nxp2_reg <= nxp_reg;
            nzp2_reg <= nzp_reg;
            ny2_reg  <= ny1_reg;
            item_reg <= item_next;
        end
    end

    // rounding, saturation, reject and interior flags, and mesh indices
    always_comb
    begin
        logic signed [47:0] nx_r;
        logic signed [47:0] nz_r;
        row_l = meta_reg[tmvg_pkg::META_LEN-1][7:0];
        col_l = meta_reg[tmvg_pkg::META_LEN-1][15:8];
        bad_counts = (rows_count_reg < 9'd2) || (cols_count_reg < 9'd2)
                  || (rows_count_reg > 9'(tmvg_pkg::MAX_DIVISIONS))
                  || (cols_count_reg > 9'(tmvg_pkg::MAX_DIVISIONS));
        item_next.reject = bad_counts || ({1'b0, row_l} >= rows_count_reg)
                        || ({1'b0, col_l} >= cols_count_reg);
        item_next.interior = ({1'b0, row_l} + 9'd1 < rows_count_reg)
                          && ({1'b0, col_l} + 9'd1 < cols_count_reg);
        item_next.pos_x  = tmvg_pkg::sat18(tmvg_pkg::round_shift(pxp_reg, 28));
        item_next.pos_y  = tmvg_pkg::sat18(tmvg_pkg::round_shift(48'(pyp2_reg), 14));
        item_next.pos_z  = tmvg_pkg::sat18(tmvg_pkg::round_shift(pzp_reg, 28));
        nx_r = tmvg_pkg::round_shift(48'(nxp2_reg), 14);
        nz_r = tmvg_pkg::round_shift(48'(nzp2_reg), 14);
        item_next.norm_x = nx_r[15:0];
        item_next.norm_y = ny2_reg;
        item_next.norm_z = nz_r[15:0];
        item_next.tex_u  = tu_reg[tmvg_pkg::TEX_LEN-1];
        item_next.tex_v  = tv_reg[tmvg_pkg::TEX_LEN-1];
        idx_prod = row_l * cols_count_reg;
        item_next.p00 = idx_prod[15:0] + {8'h00, col_l};
        item_next.p01 = item_next.p00 + 16'd1;
        item_next.p10 = item_next.p00 + {7'd0, cols_count_reg};
        item_next.p11 = item_next.p10 + 16'd1;
    end

    tmvg_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_reg),
        .item_valid (vld_reg[tmvg_pkg::PIPE_LEN-1]),
        .done       (done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire
